### hdl/wdrd_pkg.sv
`default_nettype none
package wdrd_pkg;

	localparam logic [2:0] MODE_CLEAR = 3'd0;
	localparam logic [2:0] MODE_LOAD = 3'd1;
	localparam logic [2:0] MODE_DIFF = 3'd2;
	localparam logic [2:0] MODE_CAPTURE = 3'd3;
	localparam logic [2:0] MODE_SNAP_RESET = 3'd4;

	localparam logic [6:0] MAX_RECTS = 7'd64;
	localparam int CAP_REG_INDEX = 0;

	typedef struct packed {
		logic [2:0] mode;
		logic [4:0] slot_index;
		logic [15:0] entry_generation;
		logic node_found;
		logic [31:0] node_version;
		logic [7:0] widget_kind;
		logic signed [15:0] frame_x;
		logic signed [15:0] frame_y;
		logic signed [15:0] frame_width;
		logic signed [15:0] frame_height;
	} in_item_t;

	typedef struct packed {
		logic signed [15:0] rect_x;
		logic signed [15:0] rect_y;
		logic signed [15:0] rect_width;
		logic signed [15:0] rect_height;
		logic rect_valid;
		logic diff_status;
		logic last_result;
		logic [6:0] rect_count;
	} out_item_t;

	typedef struct packed {
		logic signed [15:0] x;
		logic signed [15:0] y;
		logic signed [15:0] w;
		logic signed [15:0] h;
	} frame_t;

	typedef struct packed {
		logic [15:0] gen;
		logic [31:0] ver;
		logic [7:0] kind;
		frame_t fr;
	} slot_rec_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_COUNT,
		ST_JUDGE,
		ST_EMIT
	} wdrd_state_t;

	typedef struct packed {
		logic table_op;
		logic walk_clr;
		logic diff_init;
		logic count_step;
		logic emit_step;
		logic emit_err;
		logic emit_none;
	} wdrd_cmd_t;

	typedef struct packed {
		logic count_end;
		logic emit_end;
		logic over;
		logic none;
	} wdrd_status_t;

endpackage
`default_nettype wire

### hdl/wdrd_ctrl.sv
`default_nettype none
module wdrd_ctrl (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic start,
	input wire logic [2:0] mode,
	input wire wdrd_pkg::wdrd_status_t sts,
	output wdrd_pkg::wdrd_cmd_t cmd,
	output logic busy
);
	import wdrd_pkg::*;

	wdrd_state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (start && mode == MODE_DIFF) state_d = ST_COUNT;
			end
			ST_COUNT: begin
				if (sts.count_end) state_d = ST_JUDGE;
			end
			ST_JUDGE: begin
				if (sts.over || sts.none) state_d = ST_IDLE;
				else state_d = ST_EMIT;
			end
			ST_EMIT: begin
				if (sts.emit_end) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd = '0;
		busy = (state_q != ST_IDLE);
		unique case (state_q)
			ST_IDLE: begin
				cmd.table_op = start && mode != MODE_DIFF;
				cmd.walk_clr = start && mode == MODE_DIFF;
				cmd.diff_init = start && mode == MODE_DIFF;
			end
			ST_COUNT: cmd.count_step = 1'b1;
			ST_JUDGE: begin
				cmd.walk_clr = 1'b1;
				cmd.emit_err = sts.over;
				cmd.emit_none = !sts.over && sts.none;
			end
			ST_EMIT: cmd.emit_step = 1'b1;
			default: cmd = '0;
		endcase
	end

endmodule
`default_nettype wire

### hdl/wdrd_datapath.sv
`default_nettype none
module wdrd_datapath #(
	parameter int SLOT_COUNT = 32
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire wdrd_pkg::in_item_t item,
	input wire wdrd_pkg::wdrd_cmd_t cmd,
	input wire logic [6:0] capacity,
	output wdrd_pkg::wdrd_status_t sts,
	output logic result_strobe,
	output wdrd_pkg::out_item_t result
);
	import wdrd_pkg::*;

	localparam int IW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
	localparam logic [IW-1:0] LAST_IDX = IW'(SLOT_COUNT - 1);

	logic [SLOT_COUNT-1:0] cur_present_q, snap_present_q;
	slot_rec_t cur_tab_q [SLOT_COUNT];
	slot_rec_t snap_tab_q [SLOT_COUNT];

	logic [IW-1:0] idx_q;
	logic sub_q;
	logic [6:0] total_q, emitted_q;
	logic [6:0] cap_eff;

	slot_rec_t o_rec, c_rec;
	logic o_pres, c_pres, moved, changed;
	logic cand0, cand1;
	frame_t fr0, fr1, fr_sel;
	logic ok0, ok1, ok_sel;
	logic [1:0] n_slot;

	assign cap_eff = (capacity > MAX_RECTS) ? MAX_RECTS : capacity;

	// candidate rectangles of the slot under the walk pointer
	always_comb begin
		o_rec = snap_tab_q[idx_q];
		c_rec = cur_tab_q[idx_q];
		o_pres = snap_present_q[idx_q];
		c_pres = cur_present_q[idx_q];
		moved = (o_rec.fr != c_rec.fr);
		changed = moved || o_rec.gen != c_rec.gen || o_rec.kind != c_rec.kind
			|| o_rec.ver != c_rec.ver;
		cand0 = (o_pres && c_pres) ? changed : (o_pres || c_pres);
		fr0 = o_pres ? o_rec.fr : c_rec.fr;
		cand1 = o_pres && c_pres && moved;
		fr1 = c_rec.fr;
		ok0 = cand0 && fr0.w > 16'sd0 && fr0.h > 16'sd0;
		ok1 = cand1 && fr1.w > 16'sd0 && fr1.h > 16'sd0;
		n_slot = 2'(ok0) + 2'(ok1);
		fr_sel = sub_q ? fr1 : fr0;
		ok_sel = sub_q ? ok1 : ok0;
	end

	assign sts.count_end = (idx_q == LAST_IDX);
	assign sts.emit_end = (idx_q == LAST_IDX) && sub_q;
	assign sts.over = (total_q > cap_eff);
	assign sts.none = (total_q == 7'd0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_present_q <= '0;
			snap_present_q <= '0;
		end else if (cmd.table_op) begin
			unique case (item.mode)
				MODE_CLEAR: cur_present_q <= '0;
				MODE_LOAD: begin
					if (item.node_found && 32'(item.slot_index) < SLOT_COUNT)
						cur_present_q[item.slot_index[IW-1:0]] <= 1'b1;
				end
				MODE_CAPTURE: snap_present_q <= cur_present_q;
				MODE_SNAP_RESET: snap_present_q <= '0;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.table_op) begin
			if (item.mode == MODE_LOAD && item.node_found
					&& 32'(item.slot_index) < SLOT_COUNT) begin
				cur_tab_q[item.slot_index[IW-1:0]] <= '{gen: item.entry_generation,
					ver: item.node_version, kind: item.widget_kind,
					fr: '{x: item.frame_x, y: item.frame_y,
					w: item.frame_width, h: item.frame_height}};
			end
			if (item.mode == MODE_CAPTURE) snap_tab_q <= cur_tab_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= '0;
			sub_q <= 1'b0;
			total_q <= '0;
			emitted_q <= '0;
			result_strobe <= 1'b0;
		end else begin
			result_strobe <= 1'b0;
			if (cmd.walk_clr) begin
				idx_q <= '0;
				sub_q <= 1'b0;
				emitted_q <= '0;
			end
			// a new diff restarts the count
			if (cmd.diff_init) total_q <= '0;
			if (cmd.count_step) begin
				total_q <= total_q + 7'(n_slot);
				idx_q <= idx_q + IW'(1);
			end
			if (cmd.emit_step) begin
				sub_q <= !sub_q;
				if (sub_q) idx_q <= idx_q + IW'(1);
				if (ok_sel) begin
					emitted_q <= emitted_q + 7'd1;
					result_strobe <= 1'b1;
				end
			end
			if (cmd.emit_err || cmd.emit_none) result_strobe <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit_err) begin
			result <= '{rect_x: '0, rect_y: '0, rect_width: '0, rect_height: '0,
				rect_valid: 1'b0, diff_status: 1'b1, last_result: 1'b1,
				rect_count: cap_eff};
		end else if (cmd.emit_none) begin
			result <= '{rect_x: '0, rect_y: '0, rect_width: '0, rect_height: '0,
				rect_valid: 1'b0, diff_status: 1'b0, last_result: 1'b1,
				rect_count: 7'd0};
		end else if (cmd.emit_step && ok_sel) begin
			result <= '{rect_x: fr_sel.x, rect_y: fr_sel.y, rect_width: fr_sel.w,
				rect_height: fr_sel.h, rect_valid: 1'b1, diff_status: 1'b0,
				last_result: (emitted_q + 7'd1 == total_q),
				rect_count: emitted_q + 7'd1};
		end
	end

`ifndef SYNTH
	a_err_shape: assert property (@(posedge clk) disable iff (!arst_n)
		result_strobe && result.diff_status |-> !result.rect_valid && result.last_result)
		else $error("overflow result carries a rectangle");
	a_count_nz: assert property (@(posedge clk) disable iff (!arst_n)
		result_strobe && result.rect_valid |-> result.rect_count != 7'd0)
		else $error("rectangle with zero count");
	a_cmd_excl: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.count_step |-> !cmd.emit_step && !cmd.table_op)
		else $error("count and emit passes overlap");
`endif

endmodule
`default_nettype wire

### hdl/widget_damage_rect_diff.sv
`default_nettype none
// latency: clear, load, capture and snapshot reset take effect at the accepting edge
// diff: a count pass over every slot, a decision state, then an emit pass over two
//   candidates per slot, one candidate rectangle a cycle; results are registered
// throughput: non-diff commands one per cycle while idle; a diff is busy through its
//   count, decision and emit, or count and decision on an overflow or bare end marker
// results are strobed for one cycle each, the receiver cannot stall
// reset clears present bits of both tables and sets damage_capacity to 64
module widget_damage_rect_diff #(
	parameter int SLOT_COUNT = 32
) (
	input wire logic clk,
	input wire logic arst_n,
	// command side
	input wire logic start,
	output logic busy,
	input wire wdrd_pkg::in_item_t in_item,
	// result side, one strobe per transfer
	output logic result_strobe,
	output wdrd_pkg::out_item_t result,
	// configuration port
	input wire logic psel,
	input wire logic penable,
	input wire logic pwrite,
	input wire logic [2:0] paddr,
	input wire logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic pready
);
	import wdrd_pkg::*;

	logic [6:0] capacity_q;
	wdrd_cmd_t cmd;
	wdrd_status_t sts;
	logic start_acc;

	assign pready = 1'b1;
	// register index is paddr/4
	assign prdata = (32'(paddr[2]) == CAP_REG_INDEX) ? {25'd0, capacity_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			capacity_q <= MAX_RECTS;
		end else if (psel && penable && pwrite && 32'(paddr[2]) == CAP_REG_INDEX) begin
			capacity_q <= pwdata[6:0];
		end
	end

	// a command transfer needs an idle controller
	assign start_acc = start && !busy;

	wdrd_ctrl u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.start(start_acc),
		.mode(in_item.mode),
		.sts(sts),
		.cmd(cmd),
		.busy(busy)
	);

	wdrd_datapath #(.SLOT_COUNT(SLOT_COUNT)) u_dp (
		.clk(clk),
		.arst_n(arst_n),
		.item(in_item),
		.cmd(cmd),
		.capacity(capacity_q),
		.sts(sts),
		.result_strobe(result_strobe),
		.result(result)
	);

endmodule
`default_nettype wire
